>>> rtl/srtns_pkg.sv
// shared types and constants for the sorted rate table with nearest search
// no dependencies; imported by srtns_cmp and the top module
`timescale 1ns / 1ps

package srtns_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int RATE_BITS   = 24;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  // fixed field widths of the channels
  localparam int RATE_FLD_W   = 24;
  localparam int MCLK_W       = 32;
  localparam int PREDIV_W     = 8;
  localparam int PIN_W        = 8;
  localparam int CFG_W        = 5;
  localparam int FOUND_W      = 4;
  localparam int TOTAL_W      = 5;

  localparam int IN_DATA_W    = 96;
  localparam int IN_USER_W    = 1;
  localparam int OUT_DATA_W   = 16;
  localparam int OUT_USED_W   = FOUND_W + 2 + TOTAL_W;

  localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = CFG_W'(16);

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic [RATE_BITS-1:0] rate;
    logic [MCLK_W-1:0]    mclk;
    logic [PREDIV_W-1:0]  prediv;
    logic [PIN_W-1:0]     pin;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic {
    OP_GT,     // key > a
    OP_MID_GE  // key >= floor((a + b) / 2)
  } cmp_op_t;

  typedef struct packed {
    cmp_op_t              op;
    logic [RATE_BITS-1:0] key;
    logic [RATE_BITS-1:0] a;
    logic [RATE_BITS-1:0] b;
  } cmp_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_CMP,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_PUSH
  } state_t;

endpackage

>>> rtl/srtns_ram.sv
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module srtns_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/srtns_cmp.sv
// shared rate compare unit: greater-than for inserts, midpoint compare for searches
// depends on srtns_pkg
`timescale 1ns / 1ps

module srtns_cmp (
  input  srtns_pkg::cmp_req_t req,
  output logic                hit
);
  import srtns_pkg::*;

  logic [RATE_BITS:0]   sum;
  logic [RATE_BITS-1:0] mid;

  // sum carries one extra bit so the midpoint never overflows
  assign sum = {1'b0, req.a} + {1'b0, req.b};
  assign mid = sum[RATE_BITS:1];

  always_comb begin
    case (req.op)
      OP_GT:     hit = (req.key > req.a);
      OP_MID_GE: hit = (req.key >= mid);
      default:   hit = 1'b0;
    endcase
  end

endmodule

>>> rtl/sorted_rate_table_nearest_search.sv
// Sorted rate table with nearest-rate search.
// Input channel (in_*): one transfer per item; in_tuser selects insert (0) or search (1).
// Result channel (out_*): exactly one result transfer per input item, in order.
// Config: cfg_wr_en with cfg_wr_data writes max_entries (reset 16); write only while idle.
// Entries live in one ram, sorted highest rate first; one compare unit is reused
// every cycle by a small sequencer that walks the table one entry per cycle.
// Insert: the entry above the hole is read and compared, and each entry of lower rate
// is shifted down one place before the new entry is written; into an empty table it is
// written at once, and a dropped insert goes straight to the result push.
// Search: one ram read and one compare per entry, straight to the result push
// when the table holds zero or one entry. The sequencer returns to idle as the output
// register is loaded, and the next item can be taken the cycle after.
// in_tready is high only while the sequencer is idle; one item is worked on at
// a time. A finished result sits in the output register, and the next item is
// taken while it waits; a stalled receiver holds the following result in the
// sequencer until the register frees.
// Reset clears the entry count (table empty), the output valid and sets
// max_entries to 16; ram contents are not cleared and are never read before written.
`timescale 1ns / 1ps

module sorted_rate_table_nearest_search (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // rate[23:0], master_clock[55:24], predivisor[63:56], pin_code[71:64],
  // desired_rate[95:72]
  input  logic [srtns_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  logic [srtns_pkg::IN_USER_W-1:0]      in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // found_index[3:0], dropped[4], table_empty[5], entry_total[10:6], zero fill
  output logic [srtns_pkg::OUT_DATA_W-1:0]     out_tdata,
  input  logic                                 cfg_wr_en,
  input  logic [srtns_pkg::CFG_W-1:0]          cfg_wr_data
);
  import srtns_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]     max_entries_r;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     k_r, k_nxt;
  logic [RATE_BITS-1:0] key_r, key_nxt;
  logic [RATE_BITS-1:0] prev_r, prev_nxt;
  entry_t               new_r, new_nxt;
  logic [FOUND_W-1:0]   found_r, found_nxt;
  logic                 dropped_r, dropped_nxt;
  logic                 empty_r, empty_nxt;

  logic                 out_valid_r, out_valid_nxt;
  logic [FOUND_W-1:0]   out_found_r, out_found_nxt;
  logic                 out_dropped_r, out_dropped_nxt;
  logic                 out_empty_r, out_empty_nxt;
  logic [TOTAL_W-1:0]   out_total_r, out_total_nxt;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENTRY_W-1:0]   ram_rdata;
  entry_t               rd_entry;

  cmp_req_t             cmp_req;
  logic                 cmp_hit;

  logic                 in_xfer;
  logic                 full;
  logic [CNT_W-1:0]     k_dec;
  logic [CNT_W-1:0]     k_inc;
  logic [CNT_W-1:0]     k_dec2;
  logic                 out_free;

  srtns_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  srtns_cmp u_cmp (
    .req (cmp_req),
    .hit (cmp_hit)
  );

  assign rd_entry  = entry_t'(ram_rdata);
  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign k_dec  = k_r - CNT_W'(1);
  assign k_inc  = k_r + CNT_W'(1);
  assign k_dec2 = k_r - CNT_W'(2);

  assign full = (LIM_W'(cnt_r) >= LIM_W'(max_entries_r)) ||
                (LIM_W'(cnt_r) >= LIM_W'(TABLE_DEPTH));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      cnt_r         <= '0;
      max_entries_r <= MAX_ENTRIES_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        max_entries_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    k_r           <= k_nxt;
    key_r         <= key_nxt;
    prev_r        <= prev_nxt;
    new_r         <= new_nxt;
    found_r       <= found_nxt;
    dropped_r     <= dropped_nxt;
    empty_r       <= empty_nxt;
    out_found_r   <= out_found_nxt;
    out_dropped_r <= out_dropped_nxt;
    out_empty_r   <= out_empty_nxt;
    out_total_r   <= out_total_nxt;
  end

  always_comb begin
    state_nxt       = state_r;
    cnt_nxt         = cnt_r;
    k_nxt           = k_r;
    key_nxt         = key_r;
    prev_nxt        = prev_r;
    new_nxt         = new_r;
    found_nxt       = found_r;
    dropped_nxt     = dropped_r;
    empty_nxt       = empty_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_found_nxt   = out_found_r;
    out_dropped_nxt = out_dropped_r;
    out_empty_nxt   = out_empty_r;
    out_total_nxt   = out_total_r;
    ram_we          = 1'b0;
    ram_waddr       = k_r[IDX_W-1:0];
    ram_wdata       = new_r;
    ram_raddr       = k_r[IDX_W-1:0];
    cmp_req.op      = OP_GT;
    cmp_req.key     = key_r;
    cmp_req.a       = rd_entry.rate;
    cmp_req.b       = rd_entry.rate;

    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          new_nxt.rate   = RATE_BITS'(in_tdata[23:0]);
          new_nxt.mclk   = in_tdata[55:24];
          new_nxt.prediv = in_tdata[63:56];
          new_nxt.pin    = in_tdata[71:64];
          found_nxt      = '0;
          dropped_nxt    = 1'b0;
          empty_nxt      = 1'b0;
          k_nxt          = '0;
          if (in_tuser[0] == MODE_INSERT) begin
            key_nxt = RATE_BITS'(in_tdata[23:0]);
            if (full) begin
              dropped_nxt = 1'b1;
              state_nxt   = S_PUSH;
            end else begin
              k_nxt     = cnt_r;
              state_nxt = S_INS_RD;
            end
          end else begin
            key_nxt = RATE_BITS'(in_tdata[95:72]);
            if (cnt_r == '0) begin
              empty_nxt = 1'b1;
              state_nxt = S_PUSH;
            end else if (cnt_r == CNT_W'(1)) begin
              state_nxt = S_PUSH;
            end else begin
              state_nxt = S_SRCH_RD;
            end
          end
        end
      end

      // k_r is the hole position; the entry above it is checked next
      S_INS_RD: begin
        if (k_r == '0) begin
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_PUSH;
        end else begin
          ram_raddr = k_dec[IDX_W-1:0];
          state_nxt = S_INS_CMP;
        end
      end

      S_INS_CMP: begin
        cmp_req.op = OP_GT;
        if (cmp_hit) begin
          // shift the lower-rate entry down into the hole
          ram_we    = 1'b1;
          ram_wdata = rd_entry;
          k_nxt     = k_dec;
          if (k_dec == '0) begin
            state_nxt = S_INS_RD;
          end else begin
            ram_raddr = k_dec2[IDX_W-1:0];
          end
        end else begin
          ram_we    = 1'b1;
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = S_PUSH;
        end
      end

      S_SRCH_RD: begin
        state_nxt = S_SRCH_CMP;
      end

      // ram data holds entry k_r, prev_r holds entry k_r - 1 when k_r is above zero
      S_SRCH_CMP: begin
        cmp_req.op = OP_MID_GE;
        cmp_req.a  = prev_r;
        cmp_req.b  = rd_entry.rate;
        if (k_r == '0) begin
          prev_nxt  = rd_entry.rate;
          k_nxt     = k_inc;
          ram_raddr = k_inc[IDX_W-1:0];
        end else if (cmp_hit) begin
          found_nxt = FOUND_W'(k_dec);
          state_nxt = S_PUSH;
        end else if (k_r == cnt_r - CNT_W'(1)) begin
          found_nxt = FOUND_W'(k_r);
          state_nxt = S_PUSH;
        end else begin
          prev_nxt  = rd_entry.rate;
          k_nxt     = k_inc;
          ram_raddr = k_inc[IDX_W-1:0];
        end
      end

      S_PUSH: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_found_nxt   = found_r;
          out_dropped_nxt = dropped_r;
          out_empty_nxt   = empty_r;
          out_total_nxt   = TOTAL_W'(cnt_r);
          state_nxt       = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - OUT_USED_W){1'b0}},
                       out_total_r, out_empty_r, out_dropped_r, out_found_r};

`ifndef NO_ASSERTIONS
  // the entry count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    LIM_W'(cnt_r) <= LIM_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // the count only ever grows by one entry per insert
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (cnt_r != $past(cnt_r))) |-> (cnt_r == $past(cnt_r) + CNT_W'(1)))
    else $error("entry count changed by other than one");

  // a result is never both a dropped insert and an empty search
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_dropped_r && out_empty_r))
    else $error("dropped and table_empty both set");

  // the table is written only while an insert is being placed
  a_write_state: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> ((state_r == S_INS_RD) || (state_r == S_INS_CMP)))
    else $error("table written outside an insert");
`endif

endmodule
